FILE: design/baee_pkg.sv
// Shared types, command codes and status codes of the array edit engine.
package baee_pkg;

	// Fixed field widths
	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 7;
	localparam int ST_W   = 3;
	localparam int CNT_W  = 7;

	typedef logic [CMD_W-1:0] op_t;
	typedef logic [ST_W-1:0]  st_t;
	typedef logic [2:0]       idx_op_t;
	typedef logic [2:0]       rd_src_t;

	// Command codes
	localparam op_t CMD_APPEND = 3'd0;
	localparam op_t CMD_INSERT = 3'd1;
	localparam op_t CMD_DELETE = 3'd2;
	localparam op_t CMD_ROTL   = 3'd3;
	localparam op_t CMD_ROTR   = 3'd4;
	localparam op_t CMD_MINMAX = 3'd5;
	localparam op_t CMD_READ   = 3'd6;

	// Result status codes
	localparam st_t ST_OK     = 3'd0;
	localparam st_t ST_BADPOS = 3'd1;
	localparam st_t ST_FULL   = 3'd2;
	localparam st_t ST_EMPTY  = 3'd3;
	localparam st_t ST_BADCMD = 3'd4;

	// Walking index updates
	localparam idx_op_t IDX_HOLD  = 3'd0;
	localparam idx_op_t IDX_ZERO  = 3'd1;
	localparam idx_op_t IDX_CNT   = 3'd2;
	localparam idx_op_t IDX_CNTM1 = 3'd3;
	localparam idx_op_t IDX_POS   = 3'd4;
	localparam idx_op_t IDX_INC   = 3'd5;
	localparam idx_op_t IDX_DEC   = 3'd6;

	// Memory read address sources
	localparam rd_src_t RS_IDX   = 3'd0;
	localparam rd_src_t RS_IDXM1 = 3'd1;
	localparam rd_src_t RS_IDXP1 = 3'd2;
	localparam rd_src_t RS_ZERO  = 3'd3;
	localparam rd_src_t RS_CNTM1 = 3'd4;

	// Controller to datapath commands
	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_src_t rd_src;
		logic    pend;
		idx_op_t idx_op;
		logic    tmp_cap;
		logic    pos_clr;
		logic    fin_wr;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    mm_init;
		logic    mm_acc;
		logic    ra_emit;
		logic    rsp;
		st_t     rsp_st;
		logic    rsp_mm;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic pos_gt_cnt;
		logic pos_ge_cnt;
		logic idx_gt_pos;
		logic idx_p1_lt_cnt;
		logic idx_lt_cnt;
	} dp_stat_t;

endpackage

FILE: design/baee_ram.sv
// Generic single write port RAM with registered read.
module baee_ram
	#(
		parameter int WIDTH = 32,
		parameter int DEPTH = 64
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic                     re,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/baee_dp.sv
// Datapath: element RAM, count, walking index, min/max and result registers.
module baee_dp
	import baee_pkg::*;
	#(
		parameter int CAPACITY = 64
	)
	(
		input  logic                     clk,
		input  logic                     arst_n,
		input  dp_cmd_t                  cmd,
		output dp_stat_t                 stat,
		input  logic [CMD_W-1:0]         command,
		input  logic signed [DATA_W-1:0] value,
		input  logic [POS_W-1:0]         position,
		output logic                     strobe,
		output logic [ST_W-1:0]          status,
		output logic signed [DATA_W-1:0] data,
		output logic signed [DATA_W-1:0] min_value,
		output logic [CNT_W-1:0]         count,
		output logic                     last
	);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	op_t              op_q;
	logic [POS_W-1:0] pos_q;
	logic [DATA_W-1:0] tmp_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    cnt_nxt;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    idx_p1;
	logic [CW-1:0]    idx_m1;
	logic [CW-1:0]    cnt_m1;
	logic [DATA_W-1:0] max_q;
	logic [DATA_W-1:0] min_q;
	logic             mm_first_q;
	logic             rd_vld_s1;
	logic             rd_last_s1;
	logic             wr_pend_s1;
	logic [AW-1:0]    wr_addr_s1;
	logic [AW-1:0]    raddr;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] rdata;
	logic             strobe_q;
	st_t              status_q;
	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] min_out_q;
	logic [CNT_W-1:0] count_q;
	logic             last_q;

	assign idx_p1 = idx_q + CW'(1);
	assign idx_m1 = idx_q - CW'(1);
	assign cnt_m1 = cnt_q - CW'(1);

	// Status back to the controller
	assign stat.op            = op_q;
	assign stat.full          = (cnt_q >= CW'(CAPACITY));
	assign stat.empty         = (cnt_q == '0);
	assign stat.pos_gt_cnt    = (pos_q > POS_W'(cnt_q));
	assign stat.pos_ge_cnt    = (pos_q >= POS_W'(cnt_q));
	assign stat.idx_gt_pos    = (POS_W'(idx_q) > pos_q);
	assign stat.idx_p1_lt_cnt = (idx_p1 < cnt_q);
	assign stat.idx_lt_cnt    = (idx_q < cnt_q);

	// Item capture and temporary element
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= command;
			pos_q <= position;
			tmp_q <= value;
		end else begin
			if (cmd.pos_clr) begin
				pos_q <= '0;
			end
			if (cmd.tmp_cap) begin
				tmp_q <= rdata;
			end
		end
	end

	// Element count
	always_comb begin
		cnt_nxt = cnt_q;
		if (cmd.cnt_inc) begin
			cnt_nxt = cnt_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			cnt_nxt = cnt_m1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	// Walking index
	always_ff @(posedge clk) begin
		case (cmd.idx_op)
			IDX_HOLD:  idx_q <= idx_q;
			IDX_ZERO:  idx_q <= '0;
			IDX_CNT:   idx_q <= cnt_q;
			IDX_CNTM1: idx_q <= cnt_m1;
			IDX_POS:   idx_q <= pos_q[CW-1:0];
			IDX_INC:   idx_q <= idx_p1;
			IDX_DEC:   idx_q <= idx_m1;
			default:   idx_q <= idx_q;
		endcase
	end

	// Read address select
	always_comb begin
		case (cmd.rd_src)
			RS_IDX:   raddr = idx_q[AW-1:0];
			RS_IDXM1: raddr = idx_m1[AW-1:0];
			RS_IDXP1: raddr = idx_p1[AW-1:0];
			RS_ZERO:  raddr = '0;
			RS_CNTM1: raddr = cnt_m1[AW-1:0];
			default:  raddr = idx_q[AW-1:0];
		endcase
	end

	// Read tracking; a move writes the read element in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			wr_pend_s1 <= 1'b0;
		end else begin
			rd_vld_s1  <= cmd.rd_en;
			wr_pend_s1 <= cmd.pend;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= idx_q[AW-1:0];
		rd_last_s1 <= (idx_p1 == cnt_q);
	end

	// Write port: pending move or final element write
	assign we    = wr_pend_s1 | cmd.fin_wr;
	assign waddr = wr_pend_s1 ? wr_addr_s1 : idx_q[AW-1:0];
	assign wdata = wr_pend_s1 ? rdata : tmp_q;

	baee_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Running max/min
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_first_q <= 1'b0;
		end else if (cmd.mm_init) begin
			mm_first_q <= 1'b1;
		end else if (cmd.mm_acc && rd_vld_s1) begin
			mm_first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mm_acc && rd_vld_s1) begin
			if (mm_first_q || ($signed(rdata) > $signed(max_q))) begin
				max_q <= rdata;
			end
			if (mm_first_q || ($signed(rdata) < $signed(min_q))) begin
				min_q <= rdata;
			end
		end
	end

	// Result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.rsp | (cmd.ra_emit & rd_vld_s1);
		end
	end

	always_ff @(posedge clk) begin
		count_q <= CNT_W'(cnt_nxt);
		if (cmd.rsp) begin
			status_q  <= cmd.rsp_st;
			data_q    <= cmd.rsp_mm ? max_q : '0;
			min_out_q <= cmd.rsp_mm ? min_q : '0;
			last_q    <= 1'b1;
		end else begin
			status_q  <= ST_OK;
			data_q    <= rdata;
			min_out_q <= '0;
			last_q    <= rd_last_s1;
		end
	end

	assign strobe    = strobe_q;
	assign status    = status_q;
	assign data      = data_q;
	assign min_value = min_out_q;
	assign count     = count_q;
	assign last      = last_q;

	// One write port: a pending move never meets the final write
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_pend_s1 && cmd.fin_wr))
		else $error("pending move collides with final write");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rsp && cmd.ra_emit && rd_vld_s1))
		else $error("two results in one cycle");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.full && cmd.cnt_inc) |-> 1'b0)
		else $error("count incremented on full array");

endmodule

FILE: design/baee_ctrl.sv
// Controller state machine sequencing each command over the datapath.
module baee_ctrl
	import baee_pkg::*;
	(
		input  logic     clk,
		input  logic     arst_n,
		input  logic     start,
		output logic     busy,
		input  dp_stat_t stat,
		output dp_cmd_t  cmd
	);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_UP   = 4'd2;
	localparam logic [3:0] S_DN   = 4'd3;
	localparam logic [3:0] S_FIN  = 4'd4;
	localparam logic [3:0] S_RCAP = 4'd5;
	localparam logic [3:0] S_MM   = 4'd6;
	localparam logic [3:0] S_MMR  = 4'd7;
	localparam logic [3:0] S_RALL = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				case (stat.op)
					CMD_APPEND: begin
						if (stat.full) begin
							cmd.rsp    = 1'b1;
							cmd.rsp_st = ST_FULL;
							state_d    = S_IDLE;
						end else begin
							cmd.idx_op = IDX_CNT;
							state_d    = S_FIN;
						end
					end
					CMD_INSERT: begin
						// position check comes before the full check
						if (stat.pos_gt_cnt) begin
							cmd.rsp    = 1'b1;
							cmd.rsp_st = ST_BADPOS;
							state_d    = S_IDLE;
						end else if (stat.full) begin
							cmd.rsp    = 1'b1;
							cmd.rsp_st = ST_FULL;
							state_d    = S_IDLE;
						end else begin
							cmd.idx_op = IDX_CNT;
							state_d    = S_UP;
						end
					end
					CMD_DELETE: begin
						if (stat.pos_ge_cnt) begin
							cmd.rsp    = 1'b1;
							cmd.rsp_st = ST_BADPOS;
							state_d    = S_IDLE;
						end else begin
							cmd.idx_op = IDX_POS;
							state_d    = S_DN;
						end
					end
					CMD_ROTL: begin
						if (stat.empty) begin
							cmd.rsp    = 1'b1;
							cmd.rsp_st = ST_OK;
							state_d    = S_IDLE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_src = RS_ZERO;
							cmd.idx_op = IDX_ZERO;
							state_d    = S_RCAP;
						end
					end
					CMD_ROTR: begin
						if (stat.empty) begin
							cmd.rsp    = 1'b1;
							cmd.rsp_st = ST_OK;
							state_d    = S_IDLE;
						end else begin
							cmd.rd_en   = 1'b1;
							cmd.rd_src  = RS_CNTM1;
							cmd.idx_op  = IDX_CNTM1;
							cmd.pos_clr = 1'b1;
							state_d     = S_RCAP;
						end
					end
					CMD_MINMAX: begin
						if (stat.empty) begin
							cmd.rsp    = 1'b1;
							cmd.rsp_st = ST_EMPTY;
							state_d    = S_IDLE;
						end else begin
							cmd.idx_op  = IDX_ZERO;
							cmd.mm_init = 1'b1;
							state_d     = S_MM;
						end
					end
					CMD_READ: begin
						if (stat.empty) begin
							cmd.rsp    = 1'b1;
							cmd.rsp_st = ST_EMPTY;
							state_d    = S_IDLE;
						end else begin
							cmd.idx_op = IDX_ZERO;
							state_d    = S_RALL;
						end
					end
					default: begin
						cmd.rsp    = 1'b1;
						cmd.rsp_st = ST_BADCMD;
						state_d    = S_IDLE;
					end
				endcase
			end
			// move elements up by one, from the top down to the bound
			S_UP: begin
				if (stat.idx_gt_pos) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RS_IDXM1;
					cmd.pend   = 1'b1;
					cmd.idx_op = IDX_DEC;
				end else begin
					state_d = S_FIN;
				end
			end
			// move elements down by one, toward the last entry
			S_DN: begin
				if (stat.idx_p1_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RS_IDXP1;
					cmd.pend   = 1'b1;
					cmd.idx_op = IDX_INC;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin_wr  = (stat.op != CMD_DELETE);
				cmd.cnt_inc = (stat.op == CMD_APPEND) || (stat.op == CMD_INSERT);
				cmd.cnt_dec = (stat.op == CMD_DELETE);
				cmd.rsp     = 1'b1;
				cmd.rsp_st  = ST_OK;
				state_d     = S_IDLE;
			end
			S_RCAP: begin
				cmd.tmp_cap = 1'b1;
				state_d     = (stat.op == CMD_ROTL) ? S_DN : S_UP;
			end
			S_MM: begin
				cmd.mm_acc = 1'b1;
				if (stat.idx_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RS_IDX;
					cmd.idx_op = IDX_INC;
				end else begin
					state_d = S_MMR;
				end
			end
			S_MMR: begin
				cmd.rsp    = 1'b1;
				cmd.rsp_st = ST_OK;
				cmd.rsp_mm = 1'b1;
				state_d    = S_IDLE;
			end
			S_RALL: begin
				cmd.ra_emit = 1'b1;
				if (stat.idx_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RS_IDX;
					cmd.idx_op = IDX_INC;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// An accepted item always leaves idle on the next edge
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// A move loop is only entered from decode or the rotate capture
	a_loop_entry: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_UP || state_q == S_DN) && $past(state_q) != state_q)
			|-> ($past(state_q) == S_DEC || $past(state_q) == S_RCAP))
		else $error("move loop entered from unexpected state");

endmodule

FILE: design/bounded_array_edit_engine.sv
// Top level of the bounded array edit engine.
//
// Holds up to CAPACITY signed 32-bit elements in a RAM plus a count. A command
// item (command, value, position) is accepted at a rising edge where start is
// high and busy is low; busy stays high until the command has finished.
// Results come out on status/data/min_value/count/last, each valid for exactly
// one cycle while strobe is high. The receiver cannot stall; every result is
// taken in the cycle it is shown. Read all gives one result per element with
// last on the final one; every other command gives a single result.
// Rejects, bad commands and empty cases answer from decode; append writes
// at the end; insert and delete shift the elements from the position on;
// rotates shift all; minmax and read all scan all, read all streaming its
// results one per cycle. The rate is set by the single RAM read and write
// port: moves, scans and readout walk the stored elements one access per cycle.
// Reset clears the count and controller; RAM contents are never cleared, since
// only entries below the count are ever read.
module bounded_array_edit_engine
	import baee_pkg::*;
	#(
		parameter int CAPACITY = 64
	)
	(
		input  logic                     clk,
		input  logic                     arst_n,
		input  logic                     start,
		output logic                     busy,
		input  logic [CMD_W-1:0]         command,
		input  logic signed [DATA_W-1:0] value,
		input  logic [POS_W-1:0]         position,
		output logic                     strobe,
		output logic [ST_W-1:0]          status,
		output logic signed [DATA_W-1:0] data,
		output logic signed [DATA_W-1:0] min_value,
		output logic [CNT_W-1:0]         count,
		output logic                     last
	);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	baee_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (dp_stat),
		.cmd    (dp_cmd)
	);

	baee_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.command   (command),
		.value     (value),
		.position  (position),
		.strobe    (strobe),
		.status    (status),
		.data      (data),
		.min_value (min_value),
		.count     (count),
		.last      (last)
	);

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the array edit engine: a directed table, then random commands.
module testbench
	import baee_pkg::*;
	();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP       = 64;
	localparam int N_RANDOM  = 500;
	localparam int MAX_CYC   = 400000;
	localparam int SETTLE    = 150;
	localparam int N_DIR     = 25;
	// The package names codes 0..6 only; 7 is the illegal command
	localparam op_t CMD_BAD  = 3'd7;

	// One expected or observed result
	typedef struct packed {
		st_t         st;
		logic [31:0] dat;
		logic [31:0] mn;
		logic [6:0]  cnt;
		logic        lst;
	} edit_result_t;

	// One row of the directed table; typed rows carry their own expectation
	typedef struct packed {
		op_t         cmd;
		logic [31:0] val;
		logic [6:0]  pos;
		logic        typed;
		st_t         st;
		logic [31:0] dat;
		logic [31:0] mn;
		logic [6:0]  cnt;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	op_t command = CMD_APPEND;
	logic signed [31:0] value = '0;
	logic [6:0] position = '0;
	logic busy;
	logic strobe;
	logic [ST_W-1:0] status;
	logic signed [31:0] data;
	logic signed [31:0] min_value;
	logic [6:0] count;
	logic last;

	// Shadow of the block's array and count
	logic [31:0] shadow_elems [CAP];
	int unsigned shadow_count;
	edit_result_t owed_results [$];

	int fail_count = 0;
	int cycles = 0;
	int burst_left = 0;
	bit growing = 1'b1;

	dir_row_t dir_rows [N_DIR] = '{
		'{CMD_MINMAX, 32'h0,        7'd0,   1'b1, ST_EMPTY,  32'h0,        32'h0,        7'd0},
		'{CMD_READ,   32'h0,        7'd0,   1'b1, ST_EMPTY,  32'h0,        32'h0,        7'd0},
		'{CMD_ROTL,   32'h0,        7'd0,   1'b1, ST_OK,     32'h0,        32'h0,        7'd0},
		'{CMD_ROTR,   32'h0,        7'd127, 1'b1, ST_OK,     32'h0,        32'h0,        7'd0},
		'{CMD_DELETE, 32'h0,        7'd0,   1'b1, ST_BADPOS, 32'h0,        32'h0,        7'd0},
		'{CMD_INSERT, 32'h5,        7'd1,   1'b1, ST_BADPOS, 32'h0,        32'h0,        7'd0},
		'{CMD_BAD,    32'hFFFFFFFF, 7'd127, 1'b1, ST_BADCMD, 32'h0,        32'h0,        7'd0},
		'{CMD_APPEND, 32'h7FFFFFFF, 7'd0,   1'b1, ST_OK,     32'h0,        32'h0,        7'd1},
		'{CMD_INSERT, 32'h80000000, 7'd0,   1'b1, ST_OK,     32'h0,        32'h0,        7'd2},
		'{CMD_INSERT, 32'h0,        7'd2,   1'b1, ST_OK,     32'h0,        32'h0,        7'd3},
		'{CMD_INSERT, 32'hFFFFFFFF, 7'd1,   1'b1, ST_OK,     32'h0,        32'h0,        7'd4},
		'{CMD_MINMAX, 32'h0,        7'd0,   1'b1, ST_OK,     32'h7FFFFFFF, 32'h80000000, 7'd4},
		'{CMD_READ,   32'h0,        7'd0,   1'b0, ST_OK,     32'h0,        32'h0,        7'd0},
		'{CMD_ROTL,   32'h0,        7'd0,   1'b1, ST_OK,     32'h0,        32'h0,        7'd4},
		'{CMD_READ,   32'h0,        7'd0,   1'b0, ST_OK,     32'h0,        32'h0,        7'd0},
		'{CMD_ROTR,   32'h0,        7'd0,   1'b1, ST_OK,     32'h0,        32'h0,        7'd4},
		'{CMD_READ,   32'h0,        7'd0,   1'b0, ST_OK,     32'h0,        32'h0,        7'd0},
		'{CMD_DELETE, 32'h0,        7'd3,   1'b1, ST_OK,     32'h0,        32'h0,        7'd3},
		'{CMD_DELETE, 32'h0,        7'd0,   1'b1, ST_OK,     32'h0,        32'h0,        7'd2},
		'{CMD_DELETE, 32'h0,        7'd2,   1'b1, ST_BADPOS, 32'h0,        32'h0,        7'd2},
		'{CMD_INSERT, 32'h1,        7'd127, 1'b1, ST_BADPOS, 32'h0,        32'h0,        7'd2},
		'{CMD_INSERT, 32'h1,        7'd3,   1'b1, ST_BADPOS, 32'h0,        32'h0,        7'd2},
		'{CMD_MINMAX, 32'h0,        7'd0,   1'b0, ST_OK,     32'h0,        32'h0,        7'd0},
		'{CMD_ROTL,   32'h0,        7'd0,   1'b0, ST_OK,     32'h0,        32'h0,        7'd0},
		'{CMD_READ,   32'h0,        7'd0,   1'b0, ST_OK,     32'h0,        32'h0,        7'd0}
	};

	bounded_array_edit_engine #(.CAPACITY(CAP)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.value     (value),
		.position  (position),
		.strobe    (strobe),
		.status    (status),
		.data      (data),
		.min_value (min_value),
		.count     (count),
		.last      (last)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYC) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Queue one result; count is the shadow count after the command
	task automatic owe(st_t st, logic [31:0] dat, logic [31:0] mn, logic lst);
		owed_results.push_back('{st, dat, mn, shadow_count[6:0], lst});
	endtask

	// Apply one accepted command to the shadow and queue its results
	task automatic apply_edit(op_t cmd, logic [31:0] val, int unsigned pos);
		logic [31:0] keep;
		logic [31:0] hi;
		logic [31:0] lo;
		int i;
		case (cmd)
			CMD_APPEND: begin
				if (shadow_count >= CAP) begin
					owe(ST_FULL, '0, '0, 1'b1);
				end else begin
					shadow_elems[shadow_count] = val;
					shadow_count++;
					owe(ST_OK, '0, '0, 1'b1);
				end
			end
			CMD_INSERT: begin
				// position is checked before capacity
				if (pos > shadow_count) begin
					owe(ST_BADPOS, '0, '0, 1'b1);
				end else if (shadow_count >= CAP) begin
					owe(ST_FULL, '0, '0, 1'b1);
				end else begin
					for (i = shadow_count; i > pos; i--)
						shadow_elems[i] = shadow_elems[i-1];
					shadow_elems[pos] = val;
					shadow_count++;
					owe(ST_OK, '0, '0, 1'b1);
				end
			end
			CMD_DELETE: begin
				if (pos >= shadow_count) begin
					owe(ST_BADPOS, '0, '0, 1'b1);
				end else begin
					for (i = pos; i + 1 < shadow_count; i++)
						shadow_elems[i] = shadow_elems[i+1];
					shadow_count--;
					owe(ST_OK, '0, '0, 1'b1);
				end
			end
			CMD_ROTL: begin
				if (shadow_count > 0) begin
					keep = shadow_elems[0];
					for (i = 0; i + 1 < shadow_count; i++)
						shadow_elems[i] = shadow_elems[i+1];
					shadow_elems[shadow_count-1] = keep;
				end
				owe(ST_OK, '0, '0, 1'b1);
			end
			CMD_ROTR: begin
				if (shadow_count > 0) begin
					keep = shadow_elems[shadow_count-1];
					for (i = shadow_count - 1; i > 0; i--)
						shadow_elems[i] = shadow_elems[i-1];
					shadow_elems[0] = keep;
				end
				owe(ST_OK, '0, '0, 1'b1);
			end
			CMD_MINMAX: begin
				if (shadow_count == 0) begin
					owe(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					hi = shadow_elems[0];
					lo = shadow_elems[0];
					for (i = 1; i < shadow_count; i++) begin
						if ($signed(shadow_elems[i]) > $signed(hi)) hi = shadow_elems[i];
						if ($signed(shadow_elems[i]) < $signed(lo)) lo = shadow_elems[i];
					end
					owe(ST_OK, hi, lo, 1'b1);
				end
			end
			CMD_READ: begin
				if (shadow_count == 0)
					owe(ST_EMPTY, '0, '0, 1'b1);
				else
					for (i = 0; i < shadow_count; i++)
						owe(ST_OK, shadow_elems[i], '0, i + 1 == shadow_count);
			end
			default: begin
				owe(ST_BADCMD, '0, '0, 1'b1);
			end
		endcase
	endtask

	// Present one item and hold it until the block takes it
	task automatic send_item(op_t cmd, logic [31:0] val, logic [6:0] pos);
		start <= 1'b1;
		command <= cmd;
		value <= val;
		position <= pos;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Idle between items: mostly short, a few long, with gap-free bursts
	task automatic idle_gap();
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if (r < 5) begin
			burst_left = $urandom_range(10, 30);
			gap = 0;
		end else if (r < 40) begin
			gap = 0;
		end else if (r < 85) begin
			gap = $urandom_range(1, 3);
		end else if (r < 97) begin
			gap = $urandom_range(4, 10);
		end else begin
			gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Element values: extremes, a narrow band for ties, or anything
	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 32'h7FFFFFFF;
		if (r < 20) return 32'h80000000;
		if (r < 25) return 32'h0;
		if (r < 30) return 32'hFFFFFFFF;
		if (r < 50) return 32'($signed($urandom_range(0, 15)) - 8);
		return $urandom;
	endfunction

	// Mostly legal positions, some anywhere in the field
	function automatic logic [6:0] pick_pos(int unsigned limit);
		if ($urandom_range(0, 99) < 15 || limit == 0)
			return 7'($urandom_range(0, 127));
		return 7'($urandom_range(0, limit - 1));
	endfunction

	// Command mix leans toward growth or toward shrinking
	function automatic op_t pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (growing) begin
			if (r < 40) return CMD_APPEND;
			if (r < 65) return CMD_INSERT;
			if (r < 73) return CMD_DELETE;
		end else begin
			if (r < 10) return CMD_APPEND;
			if (r < 20) return CMD_INSERT;
			if (r < 73) return CMD_DELETE;
		end
		if (r < 79) return CMD_ROTL;
		if (r < 85) return CMD_ROTR;
		if (r < 92) return CMD_MINMAX;
		if (r < 98) return CMD_READ;
		return CMD_BAD;
	endfunction

	function automatic void report(string what, logic [63:0] want, logic [63:0] got);
		if (fail_count < 10)
			$display("mismatch on %s: expected %0h, got %0h", what, want, got);
		fail_count++;
	endfunction

	// Result checker
	always @(posedge clk) begin : check_results
		edit_result_t want;
		if (arst_n && strobe) begin
			if (owed_results.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected result: status %0d data %0h", status, data);
				fail_count++;
			end else begin
				want = owed_results.pop_front();
				if (status !== want.st) report("status", want.st, status);
				if (data !== want.dat) report("data", want.dat, data);
				if (min_value !== want.mn) report("min_value", want.mn, min_value);
				if (count !== want.cnt) report("count", want.cnt, count);
				if (last !== want.lst) report("last", want.lst, last);
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		op_t cmd;
		logic [31:0] val;
		logic [6:0] pos;
		int k;
		shadow_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (k = 0; k < N_DIR; k++) begin
			send_item(dir_rows[k].cmd, dir_rows[k].val, dir_rows[k].pos);
			apply_edit(dir_rows[k].cmd, dir_rows[k].val, dir_rows[k].pos);
			if (dir_rows[k].typed) begin
				void'(owed_results.pop_back());
				owed_results.push_back('{dir_rows[k].st, dir_rows[k].dat, dir_rows[k].mn,
					dir_rows[k].cnt, 1'b1});
			end
			idle_gap();
		end

		// Random: swing the array between empty and full
		for (k = 0; k < N_RANDOM; k++) begin
			if (shadow_count == CAP && $urandom_range(0, 3) == 0) growing = 1'b0;
			if (shadow_count == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
			cmd = pick_cmd();
			val = pick_value();
			if (cmd == CMD_INSERT)
				pos = pick_pos(shadow_count + 1);
			else if (cmd == CMD_DELETE)
				pos = pick_pos(shadow_count);
			else
				pos = 7'($urandom_range(0, 127));
			send_item(cmd, val, pos);
			apply_edit(cmd, val, pos);
			idle_gap();
		end
		start <= 1'b0;

		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
design/baee_pkg.sv
design/baee_ram.sv
design/baee_dp.sv
design/baee_ctrl.sv
design/bounded_array_edit_engine.sv
verif/testbench.sv
